>>> src/mrr_pkg.sv
// Shared types and constants for the multiply-with-carry random range block.
package mrr_pkg;

    // Word width of generators, bounds and results
    localparam int unsigned WORD_W = 32;
    localparam int unsigned HALF_W = 16;

    // Generator multipliers and reset seeds
    localparam logic [HALF_W-1:0] MUL_Z        = 16'd36969;
    localparam logic [HALF_W-1:0] MUL_W        = 16'd18000;
    localparam logic [WORD_W-1:0] RESET_SEED_Z = 32'd362436069;
    localparam logic [WORD_W-1:0] RESET_SEED_W = 32'd521288629;
    localparam logic [WORD_W-1:0] ALL_ONES     = 32'hFFFF_FFFF;

    // Configuration register indexes
    localparam int unsigned CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SEED_Z = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SEED_W = 1'b1;

    typedef logic [WORD_W-1:0] t_word;

    // Request to the shared divider
    typedef struct packed {
        logic  start;
        t_word dividend;
        t_word divisor;
    } t_div_req;

    // Answer from the shared divider
    typedef struct packed {
        logic  done;
        t_word quotient;
    } t_div_rsp;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RAW,
        ST_DIV1,
        ST_DIV2,
        ST_OUT
    } t_state;

endpackage

>>> src/mrr_gen.sv
// Pair of multiply-with-carry generators with seed load and raw word output.
module mrr_gen (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic                        i_cfg_we,
    input  logic [mrr_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  mrr_pkg::t_word              i_cfg_wdata,
    output mrr_pkg::t_word              o_raw
);
    import mrr_pkg::*;

    t_word r_z, r_w;
    t_word n_z, n_w;

    // Next generator values: mult * low half + high half (never overflows)
    always_comb begin
        n_z = ({{HALF_W{1'b0}}, MUL_Z} * {{HALF_W{1'b0}}, r_z[HALF_W-1:0]})
            + {{HALF_W{1'b0}}, r_z[WORD_W-1:HALF_W]};
        n_w = ({{HALF_W{1'b0}}, MUL_W} * {{HALF_W{1'b0}}, r_w[HALF_W-1:0]})
            + {{HALF_W{1'b0}}, r_w[WORD_W-1:HALF_W]};
    end

    // State update: seed writes load, a step advances both
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_z <= RESET_SEED_Z;
            r_w <= RESET_SEED_W;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_SEED_Z: r_z <= i_cfg_wdata;
                CFG_SEED_W: r_w <= i_cfg_wdata;
                default:    ;
            endcase
        end else if (i_step) begin
            r_z <= n_z;
            r_w <= n_w;
        end
    end

    // raw = (z << 16) + w, mod 2^32
    assign o_raw = {r_z[HALF_W-1:0], {HALF_W{1'b0}}} + r_w;

endmodule

>>> src/mrr_div.sv
// Radix-2 restoring divider, one quotient bit per cycle; a new division is taken only when idle.
module mrr_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mrr_pkg::t_div_req i_req,
    output mrr_pkg::t_div_rsp o_rsp
);
    import mrr_pkg::*;

    localparam int unsigned CNT_W = $clog2(WORD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_W - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    t_word            r_rem;
    t_word            r_quo;
    t_word            r_den;

    logic [WORD_W:0]  shifted;
    logic             ge;
    logic [WORD_W:0]  diff;

    // One restoring step: shift in next dividend bit, trial subtract
    always_comb begin
        shifted = {r_rem, r_quo[WORD_W-1]};
        diff    = shifted - {1'b0, r_den};
        ge      = shifted >= {1'b0, r_den};
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
            r_quo <= {r_quo[WORD_W-2:0], ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

>>> src/mwc_random_in_range.sv
// Top level: request sequencer around the generators and the shared divider.
//
//  channel  | direction | payload (low bit first)
//  ---------+-----------+-------------------------------
//  s_axis   | in        | tdata: max_value[31:0]
//  m_axis   | out       | tdata: random_value[31:0]
//  cfg      | in        | index 0 seed_z, index 1 seed_w
//
// A bounded request steps the generators when it is taken, forms the raw word,
// then runs two dependent divisions on the one shared divider. Bound 0 or all
// ones skips both divisions and returns the raw word.
// Reset is synchronous and loads the default seeds. A result waits in the
// output register while the next request is taken; the sequencer holds its
// result if the output register is still full when it finishes.
module mwc_random_in_range (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request: max_value[31:0]
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [31:0]                    s_axis_tdata,
    // result: random_value[31:0]
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [31:0]                    m_axis_tdata,
    // seed writes
    input  logic                           i_cfg_we,
    input  logic [mrr_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [31:0]                    i_cfg_wdata
);
    import mrr_pkg::*;

    t_state   r_state, n_state;
    t_word    r_bound;
    t_word    r_res;
    logic     r_out_valid;
    t_word    r_out_data;

    logic     in_xfer;
    logic     out_free;
    logic     bound_raw;
    t_word    raw;
    t_div_req div_req;
    t_div_rsp div_rsp;

    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign out_free  = !r_out_valid || m_axis_tready;
    assign bound_raw = (r_bound == '0) || (r_bound == ALL_ONES);

    mrr_gen u_gen (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (in_xfer),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_raw       (raw)
    );

    mrr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (in_xfer) n_state = ST_RAW;
            ST_RAW:  n_state = bound_raw ? ST_OUT : ST_DIV1;
            ST_DIV1: if (div_rsp.done) n_state = ST_DIV2;
            ST_DIV2: if (div_rsp.done) n_state = ST_OUT;
            ST_OUT:  if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshake and divider requests
    always_comb begin
        s_axis_tready    = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = ALL_ONES;
        div_req.divisor  = r_bound + 1'b1;
        case (r_state)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_RAW: begin
                // step = 0xFFFFFFFF / (bound + 1)
                div_req.start = !bound_raw;
            end
            ST_DIV1: begin
                // result = raw / (step + 1)
                div_req.start    = div_rsp.done;
                div_req.dividend = r_res;
                div_req.divisor  = div_rsp.quotient + 1'b1;
            end
            default: ;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Payload registers: bound and working result
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_bound <= s_axis_tdata;
        end
        if (r_state == ST_RAW) begin
            r_res <= raw;
        end else if (r_state == ST_DIV2 && div_rsp.done) begin
            r_res <= div_rsp.quotient;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && out_free) begin
            r_out_data <= r_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
